### hw/rtl/sxd_pkg.sv
// Package for the sprite XOR display engine: screen constants, operation codes,
// queue entry type and back-end state type. No dependencies.
package sxd_pkg;
	localparam int ScreenRows = 64;
	localparam int ScreenCols = 128;
	localparam int RowW = 6;
	localparam int AddrW = 7;
	localparam int QDepth = 2;

	typedef enum logic [2:0] {
		OP_DRAW = 3'd0, OP_SDOWN = 3'd1, OP_SRIGHT = 3'd2, OP_SLEFT = 3'd3,
		OP_LORES = 3'd4, OP_HIRES = 3'd5, OP_READ = 3'd6, OP_CLEAR = 3'd7
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  x_pos;
		logic [7:0]  y_pos;
		logic [3:0]  row_index;
		logic [15:0] sprite_bits;
		logic        wide_sprite;
		logic        last_row;
		logic [3:0]  scroll_lines;
		logic [5:0]  read_line;
		logic        read_half;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD, ST_WAIT, ST_WR, ST_OUT
	} state_t;
endpackage

### hw/rtl/sxd_front.sv
// Front part: accepts items into a two-entry queue.
// Depends on sxd_pkg.
module sxd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sxd_pkg::item_t in_item,
	output logic           q_valid,
	input  logic           q_pop,
	output sxd_pkg::item_t q_item
);
	sxd_pkg::item_t mem_q [sxd_pkg::QDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

### hw/rtl/sxd_back.sv
// Back part: framebuffer as a 64-row memory (128 bits per row), draw, scroll,
// clear and read sequencer. Depends on sxd_pkg.
module sxd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           half_scroll_quirk,
	input  logic           q_valid,
	output logic           q_pop,
	input  sxd_pkg::item_t q_item,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [63:0]    pixel_word,
	output logic [4:0]     flag_value,
	output logic           flag_valid
);
	logic [127:0] fb [sxd_pkg::ScreenRows];
	logic [63:0] vld_q;
	logic [127:0] rd_q;
	logic [5:0] rd_addr, wr_addr;
	logic [127:0] wr_data;
	logic wr_en, rd_en;

	sxd_pkg::state_t st_q, st_d;
	sxd_pkg::item_t it_q;
	logic hires_q;
	logic [4:0] tally_q, tally_d;
	logic [6:0] row_q, row_d;
	logic [1:0] line_q, line_d;
	logic hit_q, hit_d;
	logic [63:0] pix_q, pix_d;
	logic [4:0] fv_q, fv_d;
	logic fvl_q, fvl_d;
	logic out_v_q, out_v_d;
	logic hires_d, clear_all;

	// geometry of current draw
	logic dbl;
	logic [6:0] fx;
	logic [7:0] fy;
	logic [15:0] dat;
	logic [127:0] mask;
	logic [143:0] wide_m;
	logic [4:0] nsh;
	logic [6:0] src;
	logic [127:0] rdv;
	integer b;

	assign dbl = !half_scroll_quirk && !hires_q;
	assign rdv = vld_q[rd_addr] ? rd_q : 128'd0;

	always_comb begin
		dat = 16'd0;
		if (!hires_q) begin
			for (b = 0; b < 8; b++) dat[2 * b +: 2] = {2{it_q.sprite_bits[b]}};
			fx = {it_q.x_pos[5:0], 1'b0};
			fy = {1'b0, it_q.y_pos[4:0], 1'b0} + {3'd0, it_q.row_index, 1'b0};
		end else begin
			dat = it_q.wide_sprite ? it_q.sprite_bits : {it_q.sprite_bits[7:0], 8'd0};
			fx = it_q.x_pos[6:0];
			fy = {2'b0, it_q.y_pos[5:0]} + {4'd0, it_q.row_index};
		end
		wide_m = {dat, 128'd0} >> fx;
		mask = wide_m[143:16];
	end

	always_ff @(posedge clk) begin
		if (wr_en) fb[wr_addr] <= wr_data;
		if (rd_en) rd_q <= fb[rd_addr];
	end

	always_comb begin
		st_d = st_q;
		row_d = row_q;
		line_d = line_q;
		hit_d = hit_q;
		tally_d = tally_q;
		hires_d = hires_q;
		pix_d = pix_q;
		fv_d = fv_q;
		fvl_d = fvl_q;
		out_v_d = out_v_q;
		q_pop = 1'b0;
		rd_en = 1'b0;
		rd_addr = row_q[5:0];
		wr_en = 1'b0;
		wr_addr = row_q[5:0];
		wr_data = 128'd0;
		clear_all = 1'b0;
		nsh = {1'b0, it_q.scroll_lines} << dbl;
		src = row_q - {2'b0, nsh};
		if (out_v_q && out_ready) out_v_d = 1'b0;
		case (st_q)
			sxd_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					row_d = 7'd0;
					line_d = 2'd0;
					hit_d = 1'b0;
					st_d = sxd_pkg::ST_RD;
					case (q_item.op)
						sxd_pkg::OP_SDOWN: row_d = 7'd63;
						sxd_pkg::OP_LORES: begin hires_d = 1'b0; st_d = sxd_pkg::ST_OUT; end
						sxd_pkg::OP_HIRES: begin hires_d = 1'b1; st_d = sxd_pkg::ST_OUT; end
						sxd_pkg::OP_CLEAR: begin clear_all = 1'b1; st_d = sxd_pkg::ST_OUT; end
						default: ;
					endcase
				end
			end
			sxd_pkg::ST_RD: begin
				st_d = sxd_pkg::ST_WAIT;
				rd_en = 1'b1;
				case (it_q.op)
					sxd_pkg::OP_DRAW: begin
						rd_addr = fy[5:0] + {4'd0, line_q};
						if (!hires_q && fy >= 8'd63) st_d = sxd_pkg::ST_OUT;
						else if (hires_q && fy >= 8'd64) begin
							tally_d = (tally_q == 5'd31) ? tally_q : tally_q + 5'd1;
							st_d = sxd_pkg::ST_OUT;
						end
					end
					sxd_pkg::OP_SDOWN: rd_addr = src[5:0];
					sxd_pkg::OP_READ: rd_addr = it_q.read_line;
					default: rd_addr = row_q[5:0];
				endcase
			end
			sxd_pkg::ST_WAIT: begin
				st_d = sxd_pkg::ST_WR;
				case (it_q.op)
					sxd_pkg::OP_DRAW: rd_addr = fy[5:0] + {4'd0, line_q};
					sxd_pkg::OP_SDOWN: rd_addr = src[5:0];
					sxd_pkg::OP_READ: rd_addr = it_q.read_line;
					default: rd_addr = row_q[5:0];
				endcase
				if (it_q.op == sxd_pkg::OP_READ) st_d = sxd_pkg::ST_OUT;
			end
			sxd_pkg::ST_WR: begin
				wr_en = 1'b1;
				st_d = sxd_pkg::ST_RD;
				case (it_q.op)
					sxd_pkg::OP_DRAW: begin
						wr_addr = fy[5:0] + {4'd0, line_q};
						rd_addr = wr_addr;
						wr_data = rdv ^ mask;
						hit_d = hit_q || ((rdv & mask) != 128'd0);
						if (hires_q || line_q == 2'd1) begin
							if (hit_d) begin
								if (hires_q)
									tally_d = (tally_q == 5'd31) ? tally_q : tally_q + 5'd1;
								else if (tally_q == 5'd0) tally_d = 5'd1;
							end
							st_d = sxd_pkg::ST_OUT;
						end else line_d = 2'd1;
					end
					sxd_pkg::OP_SDOWN: begin
						rd_addr = src[5:0];
						wr_data = (row_q >= {2'b0, nsh}) ? rdv : 128'd0;
						if (row_q == 7'd0) st_d = sxd_pkg::ST_OUT;
						else row_d = row_q - 7'd1;
					end
					default: begin
						wr_data = (it_q.op == sxd_pkg::OP_SRIGHT) ?
							(rdv >> (dbl ? 8 : 4)) : (rdv << (dbl ? 8 : 4));
						if (row_q == 7'd63) st_d = sxd_pkg::ST_OUT;
						else row_d = row_q + 7'd1;
					end
				endcase
			end
			sxd_pkg::ST_OUT: begin
				if (it_q.op == sxd_pkg::OP_READ) rd_addr = it_q.read_line;
				if (!out_v_q || out_ready) begin
					out_v_d = 1'b1;
					pix_d = 64'd0;
					fv_d = 5'd0;
					fvl_d = 1'b0;
					if (it_q.op == sxd_pkg::OP_READ)
						pix_d = it_q.read_half ? rdv[63:0] : rdv[127:64];
					if (it_q.op == sxd_pkg::OP_DRAW && it_q.last_row) begin
						fvl_d = 1'b1;
						fv_d = tally_q;
						tally_d = 5'd0;
					end
					st_d = sxd_pkg::ST_IDLE;
				end
			end
			default: st_d = sxd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == sxd_pkg::ST_IDLE && q_valid) it_q <= q_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sxd_pkg::ST_IDLE;
			hires_q <= 1'b0;
			tally_q <= 5'd0;
			row_q <= 7'd0;
			line_q <= 2'd0;
			hit_q <= 1'b0;
			pix_q <= 64'd0;
			fv_q <= 5'd0;
			fvl_q <= 1'b0;
			out_v_q <= 1'b0;
			vld_q <= 64'd0;
		end else begin
			st_q <= st_d;
			hires_q <= hires_d;
			tally_q <= tally_d;
			row_q <= row_d;
			line_q <= line_d;
			hit_q <= hit_d;
			pix_q <= pix_d;
			fv_q <= fv_d;
			fvl_q <= fvl_d;
			out_v_q <= out_v_d;
			if (clear_all) vld_q <= 64'd0;
			else if (wr_en) vld_q[wr_addr] <= 1'b1;
		end
	end

	assign out_valid = out_v_q;
	assign pixel_word = pix_q;
	assign flag_value = fv_q;
	assign flag_valid = fvl_q;
endmodule

### hw/rtl/sprite_xor_display_engine_unit.sv
// Top level of the sprite XOR display engine: front queue and back sequencer.
// Depends on sxd_pkg, sxd_front, sxd_back.
//
// Usage: items enter on in_valid/in_ready with one port per field; each item
// gives exactly one result on out_valid/out_ready (pixel_word, flag_value,
// flag_valid). half_scroll_quirk is written with cfg_we/cfg_wdata while idle.
// A two-entry queue separates acceptance from execution.
// The back end finishes each item before it takes the next from the queue.
// Mode set and clear go from acceptance straight to the output state; a read
// reads, waits on and outputs its row; a draw row reads, waits on and writes
// each frame row it covers, one in high res and two in low res, through the
// row memory; a row clipped at the bottom goes from read to output. Scrolls
// walk all 64 rows, reading, waiting on and writing each.
// Reset clears the mode (low res), the tally, the queue and the per-row valid
// bits, so the frame reads as blank at once. Clear also resets the valid bits.
// When the receiver stalls, the result is held in the output register; the
// back end stops before its next result while the queue fills, then in_ready
// falls.
module sprite_xor_display_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [7:0]  x_pos,
	input  logic [7:0]  y_pos,
	input  logic [3:0]  row_index,
	input  logic [15:0] sprite_bits,
	input  logic        wide_sprite,
	input  logic        last_row,
	input  logic [3:0]  scroll_lines,
	input  logic [5:0]  read_line,
	input  logic        read_half,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] pixel_word,
	output logic [4:0]  flag_value,
	output logic        flag_valid
);
	sxd_pkg::item_t in_item, q_item;
	logic q_valid, q_pop, quirk_q;

	assign in_item = '{op: sxd_pkg::op_t'(operation), x_pos: x_pos, y_pos: y_pos,
		row_index: row_index, sprite_bits: sprite_bits, wide_sprite: wide_sprite,
		last_row: last_row, scroll_lines: scroll_lines, read_line: read_line,
		read_half: read_half};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) quirk_q <= 1'b0;
		else if (cfg_we) quirk_q <= cfg_wdata;
	end

	sxd_front u_front (.clk, .arst_n, .in_valid, .in_ready, .in_item,
		.q_valid, .q_pop, .q_item);

	sxd_back u_back (.clk, .arst_n, .half_scroll_quirk(quirk_q), .q_valid, .q_pop,
		.q_item, .out_valid, .out_ready, .pixel_word, .flag_value, .flag_valid);
endmodule

### hw/rtl/sxd_checker.sv
// Port checker for the display engine top level, with its bind.
// Depends on sprite_xor_display_engine_unit ports only.
module sxd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] pixel_word,
	input logic [4:0]  flag_value,
	input logic        flag_valid
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_word))
		else $error("result changed while stalled");
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !flag_valid |-> flag_value == 5'd0)
		else $error("flag value without flag valid");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flag_valid |-> pixel_word == 64'd0)
		else $error("pixels on draw result");
endmodule

bind sprite_xor_display_engine_unit sxd_checker u_chk (.clk, .arst_n, .out_valid,
	.out_ready, .pixel_word, .flag_value, .flag_valid);

### test/tb_sprite_xor_display_engine_unit.sv
// Testbench for sprite_xor_display_engine_unit: directed table then random items,
// every result checked against a behavioral display model. Depends on sxd_pkg.
`timescale 1ns / 100ps

module tb_sprite_xor_display_engine_unit;
	import sxd_pkg::*;

	localparam int Rows = 64;
	localparam int Cols = 128;
	localparam int CycleLimit = 900000;

	typedef struct packed {
		logic [63:0] pix;
		logic [4:0]  flag;
		logic        fvalid;
	} disp_res_t;

	typedef struct {
		item_t     it;
		logic      has_exp;
		disp_res_t exp;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] operation = '0;
	logic [7:0] x_pos = '0;
	logic [7:0] y_pos = '0;
	logic [3:0] row_index = '0;
	logic [15:0] sprite_bits = '0;
	logic wide_sprite = 1'b0;
	logic last_row = 1'b0;
	logic [3:0] scroll_lines = '0;
	logic [5:0] read_line = '0;
	logic read_half = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [63:0] pixel_word;
	logic [4:0] flag_value;
	logic flag_valid;

	logic [127:0] frame [Rows];
	logic hires;
	logic [4:0] tally;
	logic quirk;
	disp_res_t exp_results[$];
	int fails = 0;
	int n_items = 0;
	int n_results = 0;
	int n_flags = 0;
	longint cycles = 0;
	logic sender_done = 1'b0;

	always #6 clk = ~clk;

	sprite_xor_display_engine_unit i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.x_pos(x_pos), .y_pos(y_pos), .row_index(row_index),
		.sprite_bits(sprite_bits), .wide_sprite(wide_sprite), .last_row(last_row),
		.scroll_lines(scroll_lines), .read_line(read_line), .read_half(read_half),
		.out_valid(out_valid), .out_ready(out_ready), .pixel_word(pixel_word),
		.flag_value(flag_value), .flag_valid(flag_valid)
	);

	function automatic logic xor_line(int y, int x, logic [127:0] v);
		logic [127:0] m;
		logic hit;
		m = v >> x;
		hit = |(frame[y] & m);
		frame[y] = frame[y] ^ m;
		return hit;
	endfunction

	function automatic void tally_inc();
		if (tally != 5'd31)
			tally = tally + 5'd1;
	endfunction

	function automatic disp_res_t display_predict(item_t it);
		disp_res_t r;
		logic dbl;
		logic hit;
		logic [127:0] d;
		int fx, fy, n, s;
		r = '0;
		dbl = !quirk && !hires;
		case (it.op)
			OP_DRAW: begin
				if (!hires) begin
					fx = (it.x_pos * 2) % Cols;
					fy = (it.y_pos * 2) % Rows + it.row_index * 2;
					if (fy + 1 < Rows) begin
						d = '0;
						for (int b = 0; b < 8; b++)
							if (it.sprite_bits[b])
								d[127 - 2 * (7 - b) -: 2] = 2'b11;
						hit = xor_line(fy, fx, d);
						hit = xor_line(fy + 1, fx, d) | hit;
						if (hit && tally == 0)
							tally = 5'd1;
					end
				end else begin
					fx = it.x_pos % Cols;
					fy = it.y_pos % Rows + it.row_index;
					if (fy >= Rows)
						tally_inc();
					else begin
						d = '0;
						if (it.wide_sprite)
							d[127 -: 16] = it.sprite_bits;
						else
							d[127 -: 8] = it.sprite_bits[7:0];
						if (xor_line(fy, fx, d))
							tally_inc();
					end
				end
				if (it.last_row) begin
					r.flag = tally;
					r.fvalid = 1'b1;
					tally = '0;
				end
			end
			OP_SDOWN: begin
				n = it.scroll_lines * (dbl ? 2 : 1);
				for (int y = Rows - 1; y >= 0; y--)
					frame[y] = (y >= n) ? frame[y - n] : '0;
			end
			OP_SRIGHT, OP_SLEFT: begin
				s = dbl ? 8 : 4;
				for (int y = 0; y < Rows; y++)
					frame[y] = (it.op == OP_SRIGHT) ? frame[y] >> s : frame[y] << s;
			end
			OP_LORES: hires = 1'b0;
			OP_HIRES: hires = 1'b1;
			OP_READ: r.pix = it.read_half ? frame[it.read_line][63:0]
				: frame[it.read_line][127:64];
			default: begin
				for (int y = 0; y < Rows; y++)
					frame[y] = '0;
			end
		endcase
		return r;
	endfunction

	function automatic item_t mk(op_t op, int x, int y, int ri, int bits, bit w, bit l,
			int sl, int rl, bit rh);
		item_t it;
		it.op = op;
		it.x_pos = 8'(x);
		it.y_pos = 8'(y);
		it.row_index = 4'(ri);
		it.sprite_bits = 16'(bits);
		it.wide_sprite = w;
		it.last_row = l;
		it.scroll_lines = 4'(sl);
		it.read_line = 6'(rl);
		it.read_half = rh;
		return it;
	endfunction

	function automatic item_t rand_item();
		item_t it;
		logic [63:0] raw;
		int p;
		raw = {$urandom, $urandom};
		it = raw[$bits(item_t) - 1:0];
		p = $urandom_range(99);
		if (p < 60)
			it.op = OP_DRAW;
		else if (p < 66)
			it.op = OP_SDOWN;
		else if (p < 70)
			it.op = OP_SRIGHT;
		else if (p < 74)
			it.op = OP_SLEFT;
		else if (p < 78)
			it.op = OP_LORES;
		else if (p < 83)
			it.op = OP_HIRES;
		else if (p < 98)
			it.op = OP_READ;
		else
			it.op = OP_CLEAR;
		if (it.op == OP_DRAW && $urandom_range(3) != 0) begin
			it.x_pos = 8'($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(70));
			it.y_pos = 8'($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(40));
			it.last_row = $urandom_range(4) == 0;
		end
		return it;
	endfunction

	task automatic idle_gap(int pct_busy);
		int g;
		if ($urandom_range(99) < pct_busy)
			return;
		g = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(3, 1);
		in_valid <= 1'b0;
		repeat (g) @(posedge clk);
	endtask

	task automatic send_item(item_t it, logic has_exp, disp_res_t want);
		disp_res_t p;
		p = display_predict(it);
		if (has_exp && p != want) begin
			$error("directed row disagrees with display model: %h vs %h", want, p);
			fails++;
		end
		exp_results.push_back(p);
		in_valid <= 1'b1;
		operation <= it.op;
		x_pos <= it.x_pos;
		y_pos <= it.y_pos;
		row_index <= it.row_index;
		sprite_bits <= it.sprite_bits;
		wide_sprite <= it.wide_sprite;
		last_row <= it.last_row;
		scroll_lines <= it.scroll_lines;
		read_line <= it.read_line;
		read_half <= it.read_half;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_items++;
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		drop_valid();
		while (exp_results.size() != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic write_quirk(logic v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		quirk = v;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (exp_results.size() == 0) begin
					$error("result with no expectation waiting");
					fails++;
				end else begin
					disp_res_t e;
					e = exp_results.pop_front();
					n_results++;
					if (flag_valid)
						n_flags++;
					if (pixel_word !== e.pix) begin
						$error("pixel_word exp %h got %h", e.pix, pixel_word);
						fails++;
					end
					if (flag_value !== e.flag) begin
						$error("flag_value exp %0d got %0d", e.flag, flag_value);
						fails++;
					end
					if (flag_valid !== e.fvalid) begin
						$error("flag_valid exp %0b got %0b", e.fvalid, flag_valid);
						fails++;
					end
				end
			end
			out_ready <= (sender_done || $urandom_range(99) < 70) ? 1'b1
				: ($urandom_range(19) == 0 ? 1'b0 : out_ready);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("[sprite_xor_display_engine_unit] ERROR");
			$finish;
		end
	end

	initial begin
		dir_row_t dir[$];
		dir_row_t row;
		for (int y = 0; y < Rows; y++)
			frame[y] = '0;
		hires = 1'b0;
		tally = '0;
		quirk = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		row.has_exp = 1'b1;
		row.exp = '0;
		row.it = mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0); dir.push_back(row);
		row.it = mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 63, 1); dir.push_back(row);
		row.has_exp = 1'b0;
		// low res: 2x2 pixels, wrap, collision, wide ignored, bottom clip
		row.it = mk(OP_DRAW, 0, 0, 0, 16'hFFFF, 1, 0, 0, 0, 0); dir.push_back(row);
		row.it = mk(OP_DRAW, 255, 255, 15, 16'h81, 0, 0, 0, 0, 0); dir.push_back(row);
		row.it = mk(OP_DRAW, 60, 0, 0, 16'hA5, 0, 0, 0, 0, 0); dir.push_back(row);
		row.it = mk(OP_DRAW, 0, 0, 0, 16'h01, 0, 1, 0, 0, 0); dir.push_back(row);
		row.it = mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 0); dir.push_back(row);
		row.it = mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1); dir.push_back(row);
		row.it = mk(OP_SDOWN, 0, 0, 0, 0, 0, 0, 15, 0, 0); dir.push_back(row);
		row.it = mk(OP_SRIGHT, 0, 0, 0, 0, 0, 0, 0, 0, 0); dir.push_back(row);
		row.it = mk(OP_SLEFT, 0, 0, 0, 0, 0, 0, 0, 0, 0); dir.push_back(row);
		row.it = mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 30, 0); dir.push_back(row);
		// high res: wide rows, right clip, bottom clip tally
		row.it = mk(OP_HIRES, 0, 0, 0, 0, 0, 0, 0, 0, 0); dir.push_back(row);
		row.it = mk(OP_DRAW, 120, 60, 0, 16'hFFFF, 1, 0, 0, 0, 0); dir.push_back(row);
		row.it = mk(OP_DRAW, 127, 63, 15, 16'hFFFF, 1, 0, 0, 0, 0); dir.push_back(row);
		row.it = mk(OP_DRAW, 120, 60, 0, 16'hFFFF, 1, 1, 0, 0, 0); dir.push_back(row);
		row.it = mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 60, 1); dir.push_back(row);
		row.it = mk(OP_SDOWN, 0, 0, 0, 0, 0, 0, 1, 0, 0); dir.push_back(row);
		row.it = mk(OP_SLEFT, 0, 0, 0, 0, 0, 0, 0, 0, 0); dir.push_back(row);
		row.it = mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 61, 1); dir.push_back(row);
		row.it = mk(OP_LORES, 0, 0, 0, 0, 0, 0, 0, 0, 0); dir.push_back(row);
		row.it = mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0); dir.push_back(row);
		row.has_exp = 1'b1;
		row.it = mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 61, 1); dir.push_back(row);

		foreach (dir[i]) begin
			send_item(dir[i].it, dir[i].has_exp, dir[i].exp);
			if (dir[i].it.op == OP_SLEFT && i < 12) begin
				drain();
				write_quirk(1'b1);
			end
		end
		drain();

		// tally saturation in high res: 40 rows all below the bottom edge
		row.exp = '0;
		send_item(mk(OP_HIRES, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, row.exp);
		for (int k = 0; k < 40; k++) begin
			row.exp.flag = 5'd31;
			row.exp.fvalid = 1'b1;
			send_item(mk(OP_DRAW, 0, 63, 15, 16'h1, 0, k == 39, 0, 0, 0), k == 39,
				row.exp);
		end
		drain();
		write_quirk(1'b0);

		for (int phase = 0; phase < 4; phase++) begin
			for (int k = 0; k < 170; k++) begin
				idle_gap(60);
				send_item(rand_item(), 1'b0, row.exp);
			end
			drain();
			write_quirk(phase[0] ? 1'b0 : 1'b1);
		end

		sender_done = 1'b1;
		drain();
		$display("Covered %0d items and %0d results, %0d collision flags reported.",
			n_items, n_results, n_flags);
		if (fails == 0 && exp_results.size() == 0)
			$display("[sprite_xor_display_engine_unit] OK");
		else
			$display("[sprite_xor_display_engine_unit] ERROR");
		$finish;
	end

endmodule
